// ----- hw/rtl/ile_pkg.sv -----
// ile_pkg: shared types and constants of the indexed list engine
// action and status codes, controller states, the command broadcast to the cells
// no dependencies
package ile_pkg;

    // index field wide enough for up to 4096 entries; positions and lengths are 7 bits wide
    localparam int ILE_AT_W = 12;
    localparam int ILE_VAL_W = 32;
    localparam int ILE_POS_W = 7;
    localparam int ILE_LEN_W = 7;

    typedef enum logic [2:0] {
        ACT_GET  = 3'd0,
        ACT_HEAD = 3'd1,
        ACT_TAIL = 3'd2,
        ACT_AT   = 3'd3,
        ACT_DEL  = 3'd4
    } ile_action_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } ile_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } ile_state_t;

    // command driven to every cell of the row
    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic [ILE_AT_W-1:0]  at;
        logic [ILE_VAL_W-1:0] value;
        logic                 load_rd;
        logic                 shift_rd;
    } ile_cmd_t;

endpackage

// ----- hw/rtl/indexed_list_engine_core.sv -----
// indexed_list_engine_core: top level of the indexed insert/delete list
// a row of ile_cell entries driven by ile_ctrl; depends on ile_pkg
//
//   channel  | direction | tdata (lowest bit up)              | tuser
//   s_axis   | in        | position[6:0], item_value[38:7]    | action[2:0]
//   m_axis   | out       | read_value[31:0], list_length[38:32] | status[1:0]
//
// adds and deletes shift the whole row at the accepting edge; the result is
// registered and moves to the output register once that is free
// a valid get loads the row's read stages and shifts them towards cell zero
// until the asked entry gets there, then registers cell zero's value
// reset clears the length and the handshake state; entries need no clearing
// the result register lets the next item be taken while a result waits
module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[6:0], item_value[38:7], zero pad
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_value[31:0], list_length[38:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    ile_cmd_t             cmd;
    logic [ILE_VAL_W-1:0] entry [CAPACITY];
    logic [ILE_VAL_W-1:0] rd    [CAPACITY];
    logic [ILE_VAL_W-1:0] read_value;
    logic [ILE_LEN_W-1:0] list_length;

    ile_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_action     (s_tuser),
        .s_position   (s_tdata[6:0]),
        .s_value      (s_tdata[38:7]),
        .cmd          (cmd),
        .rd0          (rd[0]),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_read_value (read_value),
        .m_status     (m_tuser),
        .m_length     (list_length)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ILE_VAL_W-1:0] prev_e;
        logic [ILE_VAL_W-1:0] next_e;
        logic [ILE_VAL_W-1:0] next_r;

        // end cells take their own values where no neighbour exists
        if (i == 0) begin : g_first
            assign prev_e = entry[i];
        end else begin : g_mid
            assign prev_e = entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_e = entry[i];
            assign next_r = rd[i];
        end else begin : g_inner
            assign next_e = entry[i+1];
            assign next_r = rd[i+1];
        end

        ile_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .next_rd    (next_r),
            .entry      (entry[i]),
            .rd         (rd[i])
        );
    end

    assign m_tdata = {1'b0, list_length, read_value};

endmodule

// ----- hw/rtl/ile_cell.sv -----
// ile_cell: one list entry of the cell row, with its read shift stage
// shifts up on insert, down on delete, passes read data towards cell zero
// depends on ile_pkg
module ile_cell
    import ile_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                 aclk,
    input  ile_cmd_t             cmd,
    input  logic [ILE_VAL_W-1:0] prev_entry,
    input  logic [ILE_VAL_W-1:0] next_entry,
    input  logic [ILE_VAL_W-1:0] next_rd,
    output logic [ILE_VAL_W-1:0] entry,
    output logic [ILE_VAL_W-1:0] rd
);

    localparam logic [ILE_AT_W-1:0] MY_IDX = ILE_AT_W'(INDEX);

    logic [ILE_VAL_W-1:0] entry_reg, entry_next;
    logic [ILE_VAL_W-1:0] rd_reg, rd_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (MY_IDX == cmd.at) begin
                entry_next = cmd.value;
            end else if (MY_IDX > cmd.at) begin
                entry_next = prev_entry;
            end
        end else if (cmd.del) begin
            if (MY_IDX >= cmd.at) begin
                entry_next = next_entry;
            end
        end
    end

    always_comb begin
        rd_next = rd_reg;
        if (cmd.load_rd) begin
            rd_next = entry_reg;
        end else if (cmd.shift_rd) begin
            rd_next = next_rd;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

// ----- hw/rtl/ile_ctrl.sv -----
// ile_ctrl: request decode, length counter, sequencer and result register
// drives the command of the cell row and takes read data from cell zero
// depends on ile_pkg
module ile_ctrl
    import ile_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_action,
    input  logic [ILE_POS_W-1:0] s_position,
    input  logic [ILE_VAL_W-1:0] s_value,
    output ile_cmd_t             cmd,
    input  logic [ILE_VAL_W-1:0] rd0,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ILE_VAL_W-1:0] m_read_value,
    output logic [1:0]           m_status,
    output logic [ILE_LEN_W-1:0] m_length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ILE_POS_W) ? CNT_W : ILE_POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    ile_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ILE_POS_W-1:0] cd_reg, cd_next;
    ile_status_t          res_st_reg, res_st_next;
    logic [ILE_VAL_W-1:0] res_val_reg, res_val_next;
    logic                 out_valid_reg, out_valid_next;
    ile_status_t          out_st_reg;
    logic [ILE_VAL_W-1:0] out_val_reg;
    logic [ILE_LEN_W-1:0] out_len_reg;

    logic             accept;
    logic             out_load;
    logic             full;
    logic             pos_lt;
    logic             pos_le;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    ile_action_t      act;

    assign act    = ile_action_t'(s_action);
    assign s_ready = (state_reg == S_IDLE);
    assign accept = s_valid && s_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_ready);
    assign full   = (count_reg == CAP_CNT);
    assign pos_c  = CMP_W'(s_position);
    assign cnt_c  = CMP_W'(count_reg);
    assign pos_lt = (pos_c < cnt_c);
    assign pos_le = (pos_c <= cnt_c);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (act == ACT_GET && pos_lt) ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                if (cd_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // command, counter and result
    always_comb begin
        cmd          = '0;
        cmd.value    = s_value;
        count_next   = count_reg;
        cd_next      = cd_reg;
        res_st_next  = res_st_reg;
        res_val_next = res_val_reg;
        if (accept) begin
            res_st_next  = ST_DONE;
            res_val_next = '1;
            unique case (act)
                ACT_GET: begin
                    if (pos_lt) begin
                        cmd.load_rd = 1'b1;
                        cd_next     = s_position;
                    end else begin
                        res_st_next = ST_BADPOS;
                    end
                end
                ACT_HEAD, ACT_TAIL: begin
                    if (full) begin
                        res_st_next = ST_FULL;
                    end else begin
                        cmd.ins    = 1'b1;
                        cmd.at     = (act == ACT_HEAD) ? '0 : ILE_AT_W'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_AT: begin
                    if (!pos_le) begin
                        res_st_next = ST_BADPOS;
                    end else if (full) begin
                        res_st_next = ST_FULL;
                    end else begin
                        cmd.ins    = 1'b1;
                        cmd.at     = ILE_AT_W'(s_position);
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_DEL: begin
                    if (pos_lt) begin
                        cmd.del    = 1'b1;
                        cmd.at     = ILE_AT_W'(s_position);
                        count_next = count_reg - 1'b1;
                    end else begin
                        res_st_next = ST_BADPOS;
                    end
                end
                default: res_st_next = ST_BADPOS;
            endcase
        end else if (state_reg == S_READ) begin
            if (cd_reg == '0) begin
                res_val_next = rd0;
            end else begin
                cmd.shift_rd = 1'b1;
                cd_next      = cd_reg - 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cd_reg      <= cd_next;
        res_st_reg  <= res_st_next;
        res_val_reg <= res_val_next;
        if (out_load) begin
            out_st_reg  <= res_st_reg;
            out_val_reg <= res_val_reg;
            out_len_reg <= ILE_LEN_W'(count_reg);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_val_reg;
    assign m_status     = out_st_reg;
    assign m_length     = out_len_reg;

endmodule

// ----- tb/indexed_list_engine_core_checker.sv -----
`timescale 1ns / 1ps
// indexed_list_engine_core_checker: watches both streams of the list engine, keeps a
// shadow copy of the list to work out each result and compares what comes out
// depends on ile_pkg
module indexed_list_engine_core_checker
    import ile_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // position[6:0], item_value[38:7], zero pad
    input  logic [2:0]  s_tuser,   // action[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // read_value[31:0], list_length[38:32], zero pad
    input  logic [1:0]  m_tuser,   // status[1:0]
    output int          mismatches,
    output int          results_owed
);

    typedef struct packed {
        logic [ILE_VAL_W-1:0] read_value;
        ile_status_t          status;
        logic [ILE_LEN_W-1:0] list_length;
    } list_result_t;

    logic [ILE_VAL_W-1:0] shadow_entries [CAPACITY];
    int                   shadow_len;
    list_result_t         owed_q [$];

    // applies one request to the shadow list and returns the result it gives
    function automatic list_result_t apply_request(input logic [2:0] act,
                                                   input logic [ILE_POS_W-1:0] pos,
                                                   input logic [ILE_VAL_W-1:0] val);
        list_result_t r;
        int           slot;
        logic         ins;
        r.read_value = '1;
        r.status     = ST_DONE;
        ins          = 1'b0;
        slot         = 0;
        case (act)
            ACT_GET: begin
                if (pos < shadow_len) r.read_value = shadow_entries[pos];
                else r.status = ST_BADPOS;
            end
            ACT_HEAD, ACT_TAIL: begin
                if (shadow_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    ins  = 1'b1;
                    slot = (act == ACT_HEAD) ? 0 : shadow_len;
                end
            end
            ACT_AT: begin
                // a bad position wins over a full list
                if (pos > shadow_len) r.status = ST_BADPOS;
                else if (shadow_len >= CAPACITY) r.status = ST_FULL;
                else begin
                    ins  = 1'b1;
                    slot = pos;
                end
            end
            ACT_DEL: begin
                if (pos < shadow_len) begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_len--;
                end else begin
                    r.status = ST_BADPOS;
                end
            end
            default: r.status = ST_BADPOS;
        endcase
        if (ins) begin
            for (int i = shadow_len; i > slot; i--)
                shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[slot] = val;
            shadow_len++;
        end
        r.list_length = ILE_LEN_W'(shadow_len);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            shadow_len   = 0;
            owed_q.delete();
            results_owed = 0;
            mismatches   = 0;
        end else begin
            // results first: none can come from an item taken at this same edge
            if (m_tvalid && m_tready) begin
                got.read_value  = m_tdata[31:0];
                got.list_length = m_tdata[38:32];
                got.status      = ile_status_t'(m_tuser);
                if (owed_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with none owed: value %h status %0d len %0d",
                                 $time, got.read_value, got.status, got.list_length);
                    mismatches++;
                end else begin
                    want = owed_q.pop_front();
                    if (got.read_value !== want.read_value || got.status !== want.status ||
                        got.list_length !== want.list_length) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: value %h/%h status %0d/%0d len %0d/%0d %s",
                                     $time, want.read_value, got.read_value, want.status,
                                     got.status, want.list_length, got.list_length,
                                     "(expected/actual)");
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                owed_q.push_back(apply_request(s_tuser, s_tdata[6:0], s_tdata[38:7]));
            results_owed = owed_q.size();
        end
    end

endmodule

// ----- tb/indexed_list_engine_core_tb.sv -----
`timescale 1ns / 1ps
// indexed_list_engine_core_tb: clock, reset and stimulus for the indexed list engine
// instantiates the block and indexed_list_engine_core_checker; depends on ile_pkg
module indexed_list_engine_core_tb;
    import ile_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int SEGMENTS       = 8;
    localparam int SEG_ITEMS      = 50;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;

    // action codes the block does not define
    localparam logic [2:0] ACT_SPARE5 = 3'd5;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // position[6:0], item_value[38:7], zero pad
    logic [2:0]  s_tuser  = '0;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // read_value[31:0], list_length[38:32], zero pad
    logic [1:0]  m_tuser;         // status[1:0]

    int mismatches;
    int results_owed;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;
    int fill_guess   = 0;   // list length as the stimulus sees it, only for shaping

    indexed_list_engine_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    indexed_list_engine_core_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .results_owed(results_owed)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin : receiver
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // offers one item, leaves tvalid high after the handshake
    task automatic send_item(input logic [2:0] act, input logic [ILE_POS_W-1:0] pos,
                             input logic [ILE_VAL_W-1:0] val);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, val, pos};
        do @(posedge aclk); while (!s_tready);
        case (act)
            ACT_HEAD, ACT_TAIL: if (fill_guess < CAPACITY) fill_guess++;
            ACT_AT:  if (pos <= fill_guess && fill_guess < CAPACITY) fill_guess++;
            ACT_DEL: if (pos < fill_guess) fill_guess--;
            default: ;
        endcase
    endtask

    task automatic wait_all_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
    endtask

    initial begin : stimulus
        int                   pick;
        int                   get_w;
        int                   add_w;
        int                   del_w;
        logic [2:0]           act;
        logic [ILE_POS_W-1:0] pos;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, appends at both ends, edge values and positions
        send_item(ACT_GET,  7'd0,   32'h0000_0001);
        send_item(ACT_DEL,  7'd0,   32'h0000_0002);
        send_item(ACT_AT,   7'd1,   32'h0000_0005);
        send_item(ACT_AT,   7'd0,   32'h1234_5678);
        send_item(ACT_HEAD, 7'd0,   32'h8000_0000);
        send_item(ACT_TAIL, 7'd127, 32'h7FFF_FFFF);
        send_item(ACT_AT,   7'd3,   32'hFFFF_FFFF);
        send_item(ACT_AT,   7'd1,   32'h0000_0000);
        for (int i = 0; i < 5; i++) send_item(ACT_GET, 7'(i), 32'($urandom));
        send_item(ACT_GET,  7'd5,   32'hFFFF_FFFF);
        send_item(ACT_GET,  7'd127, 32'h0000_0000);
        send_item(ACT_DEL,  7'd127, 32'h0000_0000);
        send_item(ACT_DEL,  7'd2,   32'h0000_0000);
        send_item(ACT_DEL,  7'd0,   32'h0000_0000);
        send_item(ACT_SPARE5, 7'd0,   32'($urandom));
        send_item(ACT_SPARE6, 7'd1,   32'($urandom));
        send_item(ACT_SPARE7, 7'd127, 32'hFFFF_FFFF);
        send_item(ACT_DEL,  7'(fill_guess - 1), 32'h0000_0000);
        send_item(ACT_GET,  7'd1,   32'h0000_0000);
        send_item(ACT_AT,   7'd127, 32'hAAAA_5555);
        send_item(ACT_HEAD, 7'd0,   32'h55AA_AA55);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
            endcase
            // growing runs fill the list to capacity, shrinking runs empty it again
            if (seg == 4 || seg == 5) begin
                get_w = 20; add_w = 35; del_w = 95;
            end else if (seg == 3 || seg == 7) begin
                get_w = 35; add_w = 65; del_w = 95;
            end else begin
                get_w = 15; add_w = 85; del_w = 95;
            end
            if (seg == 1) rx_hold_req = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < get_w) act = ACT_GET;
                else if (pick < add_w)
                    act = 3'($urandom_range(int'(ACT_AT), int'(ACT_HEAD)));
                else if (pick < del_w) act = ACT_DEL;
                else act = 3'($urandom_range(int'(ACT_SPARE7), int'(ACT_SPARE5)));
                if ($urandom_range(99) < 20) pos = 7'($urandom_range(127));
                else if (act == ACT_AT) pos = 7'($urandom_range(fill_guess));
                else pos = 7'($urandom_range(fill_guess > 0 ? fill_guess - 1 : 0));
                send_item(act, pos, 32'($urandom));
            end
            if (seg == 3) wait_all_results();
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
